// ===== rtl/core/bb_pkg.sv =====
`default_nettype none

package bb_pkg;

  localparam int DEF_MAX_WIDTH = 1024;

  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int FUNC_W     = 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int IN_ROW_W   = FH_W + 1;
  localparam int SUM_W      = 12;
  localparam int NUM_W      = SUM_W + 1;
  localparam int CNT_W      = 4;
  localparam int RCP_W      = 17;
  localparam int RCP_SH     = 17;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 16'd480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [FUNC_W-1:0] FUNC_DRAIN = 1'b1;

  // Rounded-up reciprocal of twice the neighbour count, scaled by 2**RCP_SH.
  // With this scaling the product with (2*sum + count) truncates to the exact quotient.
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RCP_W-1:0] m;
    case (cnt)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd5:    m = 17'd13108;
      4'd6:    m = 17'd10923;
      4'd7:    m = 17'd9363;
      4'd8:    m = 17'd8192;
      4'd9:    m = 17'd7282;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bb_ram.sv =====
`default_nettype none

module bb_ram #(
  parameter int WIDTH = bb_pkg::PIX_W,
  parameter int DEPTH = bb_pkg::DEF_MAX_WIDTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  import bb_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/bb_cell.sv =====
`default_nettype none

module bb_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift,
  input  logic                     incl,
  input  logic [bb_pkg::PIX_W-1:0] d,
  output logic [bb_pkg::PIX_W-1:0] q,
  output logic [bb_pkg::PIX_W-1:0] contrib
);
  import bb_pkg::*;

  logic [PIX_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= d;
    end
  end

  assign q       = q_r;
  assign contrib = incl ? q_r : '0;

endmodule

`default_nettype wire

// ===== rtl/core/bb_mean.sv =====
`default_nettype none

module bb_mean (
  input  logic [bb_pkg::NUM_W-1:0]  num,
  input  logic [bb_pkg::CNT_W-1:0]  cnt,
  output logic [bb_pkg::CHAN_W-1:0] mean
);
  import bb_pkg::*;

  logic [RCP_W-1:0]       rcp;
  logic [NUM_W+RCP_W-1:0] prod;

  assign rcp  = recip(cnt);
  assign prod = {{RCP_W{1'b0}}, num} * {{NUM_W{1'b0}}, rcp};
  assign mean = prod[RCP_SH+CHAN_W-1:RCP_SH];

endmodule

`default_nettype wire

// ===== rtl/core/box_blur_3x3_edge_average_unit.sv =====
`default_nettype none

// 3x3 box blur of an RGB raster stream with the neighbourhood clipped to the frame: each result
// is the per-channel mean over the neighbours inside the frame, rounded half up. Pixels enter
// in raster order; the result for a pixel leaves once frame_width+1 further items have been
// accepted, and drain transactions (func set) push out the remaining results after the last
// pixel, the final one carrying last_of_frame. A sustained rate of one transaction per clock is
// held while out_ready stays high; from acceptance to the output register an item passes the
// line memory read, the 3x3 window of cells, the summing stage and the reciprocal multiply. The
// two line memories need no clearing after reset. frame_width and frame_height are to be
// written through the configuration port only while the block is idle; the block itself does
// not enforce this.
module box_blur_3x3_edge_average_unit #(
  parameter int MAX_WIDTH = bb_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bb_pkg::FUNC_W-1:0]     in_func,
  input  logic [bb_pkg::CHAN_W-1:0]     in_red,
  input  logic [bb_pkg::CHAN_W-1:0]     in_green,
  input  logic [bb_pkg::CHAN_W-1:0]     in_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bb_pkg::CHAN_W-1:0]     out_red,
  output logic [bb_pkg::CHAN_W-1:0]     out_green,
  output logic [bb_pkg::CHAN_W-1:0]     out_blue,
  output logic                          out_last_of_frame
);
  import bb_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  typedef struct packed {
    logic row_top;
    logic row_bot;
    logic col_left;
    logic col_right;
  } mask_t;

  typedef struct packed {
    logic  recv;
    logic  result;
    logic  last;
    mask_t mask;
  } ctrl_t;

  logic [FW_W-1:0]     frame_width_r;
  logic [FH_W-1:0]     frame_height_r;
  logic [CW-1:0]       in_col_r, in_col_nxt;
  logic [IN_ROW_W-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0]       out_col_r, out_col_nxt;
  logic [FH_W-1:0]     out_row_r, out_row_nxt;

  logic [WW-1:0]    w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [CW-1:0]    col_eff, ocol_eff;
  logic [PIX_W-1:0] px;
  logic             is_drain, rx_frame, skip, col_last, ocol_last, orow_last;
  ctrl_t            a_ctrl;
  logic             fwd_a;

  logic in_fire, en_b, en_c, en_d, en_o, shift;

  logic             b_valid_r;
  ctrl_t            b_ctrl_r;
  logic [CW-1:0]    b_x_r;
  logic [PIX_W-1:0] b_px_r;
  logic             b_fwd_r;
  logic [PIX_W-1:0] b_fwd_up_r;
  logic [PIX_W-1:0] up_rd, mid_rd, up_v;

  logic             c_valid_r;
  mask_t            c_mask_r;
  logic             c_last_r;
  logic [PIX_W-1:0] col_in  [3];
  logic [PIX_W-1:0] win_d   [3][3];
  logic [PIX_W-1:0] win_q   [3][3];
  logic [PIX_W-1:0] win_c   [3][3];
  logic [2:0]       row_inc, col_inc;
  logic [SUM_W-1:0] c_sum   [3];
  logic [1:0]       c_rows, c_cols;
  logic [CNT_W-1:0] c_cnt;

  logic             d_valid_r;
  logic [NUM_W-1:0] d_num_r [3];
  logic [CNT_W-1:0] d_cnt_r;
  logic             d_last_r;
  logic [CHAN_W-1:0] mean   [3];

  logic              out_valid_r;
  logic [CHAN_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic              out_last_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake chain: each stage moves when the one after it is empty or moving.
  assign en_o     = !out_valid_r || out_ready;
  assign en_d     = !d_valid_r || en_o;
  assign en_c     = !c_valid_r || en_d;
  assign en_b     = !b_valid_r || en_c;
  assign in_ready = en_b;
  assign in_fire  = in_valid && en_b;
  assign shift    = b_valid_r && en_c;

  assign px = {in_red, in_green, in_blue};

  // Position bookkeeping for the accepted transaction.
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    h_eff     = (frame_height_r == '0) ? FH_W'(1) : frame_height_r;
    col_eff   = (WW'(in_col_r) >= w_eff) ? '0 : in_col_r;
    ocol_eff  = (WW'(out_col_r) >= w_eff) ? '0 : out_col_r;
    col_last  = (WW'(col_eff) + WW'(1)) >= w_eff;
    ocol_last = (WW'(ocol_eff) + WW'(1)) >= w_eff;
    orow_last = (IN_ROW_W'(out_row_r) + IN_ROW_W'(1)) >= IN_ROW_W'(h_eff);
    rx_frame  = in_row_r < IN_ROW_W'(h_eff);
    is_drain  = in_func == FUNC_DRAIN;
    skip      = is_drain && rx_frame;

    a_ctrl.recv   = rx_frame && !is_drain;
    a_ctrl.result = !((in_row_r == '0) || ((in_row_r == IN_ROW_W'(1)) && (col_eff == '0)));
    a_ctrl.last   = orow_last && ocol_last;
    a_ctrl.mask.row_top   = out_row_r != '0;
    a_ctrl.mask.row_bot   = !orow_last;
    a_ctrl.mask.col_left  = ocol_eff != '0;
    a_ctrl.mask.col_right = !ocol_last;

    fwd_a = b_valid_r && b_ctrl_r.recv && (b_x_r == col_eff);

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (in_fire) begin
      in_col_nxt  = col_eff;
      out_col_nxt = ocol_eff;
      if (!skip) begin
        if (col_last) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + IN_ROW_W'(1);
        end else begin
          in_col_nxt = col_eff + CW'(1);
        end
        if (a_ctrl.result) begin
          if (a_ctrl.last) begin
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
          end else if (ocol_last) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + FH_W'(1);
          end else begin
            out_col_nxt = ocol_eff + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Line memories. The middle line is written on acceptance; the upper line takes the old
  // middle entry when the item leaves the read register, so a back-to-back read of the same column is forwarded.
  bb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH), .AW(CW)) u_mid_ram (
    .clk   (clk),
    .we    (in_fire && a_ctrl.recv),
    .waddr (col_eff),
    .wdata (px),
    .re    (in_fire),
    .raddr (col_eff),
    .rdata (mid_rd)
  );

  bb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH), .AW(CW)) u_up_ram (
    .clk   (clk),
    .we    (shift && b_ctrl_r.recv),
    .waddr (b_x_r),
    .wdata (mid_rd),
    .re    (in_fire),
    .raddr (col_eff),
    .rdata (up_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en_b) begin
      b_valid_r <= in_fire && !skip;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_ctrl_r   <= a_ctrl;
      b_x_r      <= col_eff;
      b_px_r     <= px;
      b_fwd_r    <= fwd_a;
      b_fwd_up_r <= mid_rd;
    end
  end

  assign up_v      = b_fwd_r ? b_fwd_up_r : up_rd;
  assign col_in[0] = up_v;
  assign col_in[1] = mid_rd;
  assign col_in[2] = b_ctrl_r.recv ? b_px_r : '0;

  // Window of cells: each row shifts one place towards column 0 per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en_c) begin
      c_valid_r <= b_valid_r && b_ctrl_r.result;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      c_mask_r <= b_ctrl_r.mask;
      c_last_r <= b_ctrl_r.last;
    end
  end

  assign row_inc = {c_mask_r.row_bot, 1'b1, c_mask_r.row_top};
  assign col_inc = {c_mask_r.col_right, 1'b1, c_mask_r.col_left};

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      if (c < 2) begin : g_inner
        assign win_d[r][c] = win_q[r][c+1];
      end else begin : g_edge
        assign win_d[r][c] = col_in[r];
      end
      bb_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (shift),
        .incl    (row_inc[r] && col_inc[c]),
        .d       (win_d[r][c]),
        .q       (win_q[r][c]),
        .contrib (win_c[r][c])
      );
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      c_sum[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          c_sum[ch] = c_sum[ch] + SUM_W'(win_c[r][c][(2-ch)*CHAN_W +: CHAN_W]);
        end
      end
    end
    c_rows = 2'd1 + 2'(c_mask_r.row_top) + 2'(c_mask_r.row_bot);
    c_cols = 2'd1 + 2'(c_mask_r.col_left) + 2'(c_mask_r.col_right);
    c_cnt  = CNT_W'(c_rows) * CNT_W'(c_cols);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en_d) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid_r && en_d) begin
      for (int ch = 0; ch < 3; ch++) begin
        d_num_r[ch] <= (NUM_W'(c_sum[ch]) << 1) + NUM_W'(c_cnt);
      end
      d_cnt_r  <= c_cnt;
      d_last_r <= c_last_r;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_mean
    bb_mean u_mean (
      .num  (d_num_r[ch]),
      .cnt  (d_cnt_r),
      .mean (mean[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_o) begin
      out_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid_r && en_o) begin
      out_red_r   <= mean[0];
      out_green_r <= mean[1];
      out_blue_r  <= mean[2];
      out_last_r  <= d_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red           = out_red_r;
  assign out_green         = out_green_r;
  assign out_blue          = out_blue_r;
  assign out_last_of_frame = out_last_r;

  ap_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (b_valid_r && c_valid_r && d_valid_r && out_valid_r && !out_ready))
    else $error("input stalled while the pipeline has room");

  ap_skip_drain : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && skip) |=> !b_valid_r)
    else $error("ignored drain transaction entered the pipeline");

  ap_count_legal : assert property (@(posedge clk) disable iff (!rst_n)
    d_valid_r |-> (d_cnt_r == 4'd1 || d_cnt_r == 4'd2 || d_cnt_r == 4'd3 ||
                   d_cnt_r == 4'd4 || d_cnt_r == 4'd6 || d_cnt_r == 4'd9))
    else $error("neighbour count outside the possible set");

  ap_out_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(d_valid_r))
    else $error("result presented without a source in the multiply stage");

endmodule

`default_nettype wire

// ===== bench/box_blur_checker.sv =====
`timescale 1ns / 1ps

module box_blur_checker #(
  parameter int MAX_WIDTH = bb_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [bb_pkg::FUNC_W-1:0]     in_func,
  input  logic [bb_pkg::CHAN_W-1:0]     in_red,
  input  logic [bb_pkg::CHAN_W-1:0]     in_green,
  input  logic [bb_pkg::CHAN_W-1:0]     in_blue,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [bb_pkg::CHAN_W-1:0]     out_red,
  input  logic [bb_pkg::CHAN_W-1:0]     out_green,
  input  logic [bb_pkg::CHAN_W-1:0]     out_blue,
  input  logic                          out_last_of_frame,
  output int                            fail_count,
  output int                            pending_results,
  output int                            results_checked
);
  import bb_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } blur_result_t;

  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;
  logic [PIX_W-1:0] upper_row [MAX_WIDTH];
  logic [PIX_W-1:0] middle_row [MAX_WIDTH];
  logic [PIX_W-1:0] win [3][3];
  int unsigned      in_col;
  int unsigned      in_row;
  int unsigned      out_col;
  int unsigned      out_row;
  blur_result_t     expected_means [$];
  int               fails;
  int               checked;

  function automatic logic [CHAN_W-1:0] rounded_avg(input int unsigned s, input int unsigned n);
    int unsigned q;
    q = (2 * s + n) / (2 * n);
    return q[CHAN_W-1:0];
  endfunction

  // Advances the window by one transaction; returns 1 when a blurred pixel falls out.
  function automatic bit blur_step(input bit drain, input logic [PIX_W-1:0] px,
                                   output blur_result_t res);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned pos;
    int unsigned cnt;
    int unsigned sr;
    int unsigned sg;
    int unsigned sb;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] p;
    bit rx;
    w = width_reg;
    h = height_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 1) h = 1;
    if (in_col >= w) in_col = 0;
    if (out_col >= w) out_col = 0;
    rx = in_row < h;
    if (drain && rx) return 1'b0;
    rx = rx && !drain;
    x = in_col;
    up = upper_row[x];
    mid = middle_row[x];
    if (rx) begin
      upper_row[x] = mid;
      middle_row[x] = px;
    end
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = rx ? px : '0;
    pos = in_row * w + in_col;
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (pos < w + 1) return 1'b0;
    sr = 0;
    sg = 0;
    sb = 0;
    cnt = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h) ||
              (c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= w))) begin
          p = win[r][c];
          sr += p[23:16];
          sg += p[15:8];
          sb += p[7:0];
          cnt++;
        end
      end
    end
    res.red = rounded_avg(sr, cnt);
    res.green = rounded_avg(sg, cnt);
    res.blue = rounded_avg(sb, cnt);
    res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
    if (res.last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    return 1'b1;
  endfunction

  task automatic flag_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    blur_result_t got;
    blur_result_t want;
    blur_result_t res;
    if (!rst_n) begin
      width_reg = FW_RESET;
      height_reg = FH_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i] = '0;
        middle_row[i] = '0;
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win[r][c] = '0;
      end
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      expected_means.delete();
      fails = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_red, out_green, out_blue, out_last_of_frame};
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fails++;
        end else begin
          want = expected_means.pop_front();
          flag_field("out_red", want.red, got.red);
          flag_field("out_green", want.green, got.green);
          flag_field("out_blue", want.blue, got.blue);
          flag_field("out_last_of_frame", want.last, got.last);
        end
        checked++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_data[FW_W-1:0];
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_data[FH_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        if (blur_step(in_func == FUNC_DRAIN, {in_red, in_green, in_blue}, res)) begin
          expected_means.push_back(res);
        end
      end
    end
    fail_count <= fails;
    pending_results <= expected_means.size();
    results_checked <= checked;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bb_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 12;
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 1'b0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func = '0;
  logic [CHAN_W-1:0]     in_red = '0;
  logic [CHAN_W-1:0]     in_green = '0;
  logic [CHAN_W-1:0]     in_blue = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CHAN_W-1:0]     out_red;
  logic [CHAN_W-1:0]     out_green;
  logic [CHAN_W-1:0]     out_blue;
  logic                  out_last_of_frame;

  int fail_count;
  int pending_results;
  int results_checked;
  int items_sent = 0;
  int frame_items = 0;
  int frames_sent = 0;
  bit gaps_on = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  box_blur_3x3_edge_average_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_last_of_frame (out_last_of_frame)
  );

  box_blur_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_last_of_frame (out_last_of_frame),
    .fail_count        (fail_count),
    .pending_results   (pending_results),
    .results_checked   (results_checked)
  );

  function automatic logic [PIX_W-1:0] pick_pixel();
    logic [PIX_W-1:0] px;
    px = PIX_W'($urandom);
    case ($urandom_range(0, 9))
      0: px = '0;
      1: px = '1;
      default: begin
      end
    endcase
    return px;
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [PIX_W-1:0] px);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    {in_red, in_green, in_blue} <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // A noisy frame carries stray drains among its pixels and pixels among its closing drains.
  task automatic send_frame(input int w, input int h, input bit noisy);
    for (int i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_item(FUNC_DRAIN, pick_pixel());
      send_item(FUNC_PIXEL, pick_pixel());
    end
    for (int i = 0; i <= w; i++) begin
      send_item((noisy && $urandom_range(0, 5) == 0) ? FUNC_PIXEL : FUNC_DRAIN, pick_pixel());
    end
    frame_items += w * h + w + 1;
    frames_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_frame(input int w, input int h);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int w;
    int h;
    int budget;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_frame(3, 3);
    send_item(FUNC_PIXEL, 24'h000000);
    send_item(FUNC_PIXEL, 24'hFFFFFF);
    send_item(FUNC_PIXEL, 24'hFF0000);
    send_item(FUNC_PIXEL, 24'h00FF00);
    send_item(FUNC_DRAIN, 24'h123456);
    send_item(FUNC_PIXEL, 24'h0000FF);
    send_item(FUNC_PIXEL, 24'hFFFFFF);
    send_item(FUNC_PIXEL, 24'h000000);
    send_item(FUNC_PIXEL, 24'h808080);
    send_item(FUNC_PIXEL, 24'h7F017F);
    send_item(FUNC_DRAIN, 24'h000000);
    send_item(FUNC_DRAIN, 24'hFFFFFF);
    send_item(FUNC_PIXEL, 24'hA5A5A5);
    send_item(FUNC_DRAIN, 24'h5A5A5A);
    send_item(FUNC_DRAIN, 24'h000000);
    send_item(FUNC_DRAIN, 24'h000000);

    // Narrowing the frame mid-way wraps both the input and output columns.
    set_frame(3, 2);
    send_frame(3, 2, 1'b0);
    set_frame(3, 3);
    repeat (5) send_item(FUNC_PIXEL, pick_pixel());
    settle();
    write_reg(REG_FRAME_WIDTH, 1);
    cfg_valid <= 1'b0;
    repeat (2) send_item(FUNC_PIXEL, pick_pixel());
    repeat (4) send_item(FUNC_DRAIN, pick_pixel());

    gaps_on = 1'b1;
    hold_req = 1'b1;
    set_frame(40, 10);
    send_frame(40, 10, 1'b1);

    budget = frame_items + 400;
    while (frame_items < budget) begin
      gaps_on = (budget - frame_items > 150) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0: begin
          w = $urandom_range(50, 120);
          h = 1;
        end
        1, 2, 3: begin
          w = $urandom_range(9, 40);
          h = $urandom_range(1, 6);
        end
        default: begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 10);
        end
      endcase
      set_frame(w, h);
      send_frame(w, h, $urandom_range(0, 2) != 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_item(FUNC_DRAIN, pick_pixel());
      end
    end

    gaps_on = 1'b0;
    settle();
    $display("Run covered %0d frames and %0d input transactions; %0d results were checked.",
             frames_sent, items_sent, results_checked);
    $display("Widths ran from 1 to 120, heights up to 10, with a mid-frame narrowing.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout: the run did not finish in time.");
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bb_pkg.sv
rtl/core/bb_ram.sv
rtl/core/bb_cell.sv
rtl/core/bb_mean.sv
rtl/core/box_blur_3x3_edge_average_unit.sv
bench/box_blur_checker.sv
bench/tb_top.sv
